// File: sv/spat_pkg.sv
// Shared types, constants and helpers of the segment/page address translator.
// Used by the config interface, all translator modules and the checker.
// Depends on nothing.
package spat_pkg;

  // Entries in each descriptor, directory and page table (2 to 8192).
  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);

  // Widths of the indices that reach a table compare (selector index is 13 bits).
  localparam int SEL_IDX_W = 13;
  localparam int CMP_W     = SEL_IDX_W + 1;

  // Configuration registers: 11-bit table counts.
  localparam int COUNT_W   = 11;
  localparam int CFG_IDX_W = 2;

  // Command queue between front and back; a power of two, at least 2.
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GLOBAL_COUNT = 2'd0,
    CFG_LOCAL_COUNT  = 2'd1,
    CFG_DIR_COUNT    = 2'd2,
    CFG_PAGE_COUNT   = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    OP_TRANSLATE = 3'd0,
    OP_WR_GLOBAL = 3'd1,
    OP_WR_LOCAL  = 3'd2,
    OP_WR_DIR    = 3'd3,
    OP_WR_PAGE   = 3'd4
  } opcode_e;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_BAD_SELECTOR = 3'd1,
    ST_ABSENT       = 3'd2,
    ST_LIMIT        = 3'd3,
    ST_PAGE_RANGE   = 3'd4,
    ST_PAGE_ABSENT  = 3'd5,
    ST_WRITTEN      = 3'd6
  } status_e;

  // What the back end has to do with a queued command.
  typedef enum logic [2:0] {
    K_TRANSLATE,
    K_BAD_SEL,
    K_WR_GLOBAL,
    K_WR_LOCAL,
    K_WR_DIR,
    K_WR_PAGE,
    K_NOP
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e          kind;
    logic               use_local;
    logic [IDX_W-1:0]   addr;    // descriptor index or write address
    logic [31:0]        offset;
    logic [63:0]        data;
  } cmd_t;

  typedef struct packed {
    logic [COUNT_W-1:0] dir_count;
    logic [COUNT_W-1:0] page_count;
  } page_counts_t;

  // Index lies inside the physical table.
  function automatic logic in_depth(logic [SEL_IDX_W-1:0] idx);
    return CMP_W'(idx) < CMP_W'(TABLE_DEPTH);
  endfunction

  // Index lies below the programmed count and inside the table.
  function automatic logic in_table(logic [SEL_IDX_W-1:0] idx, logic [COUNT_W-1:0] count);
    return (CMP_W'(idx) < CMP_W'(count)) && in_depth(idx);
  endfunction

  // Table address from an index already known to be in depth.
  function automatic logic [IDX_W-1:0] tbl_addr(logic [SEL_IDX_W-1:0] idx);
    return idx[IDX_W-1:0];
  endfunction

endpackage

// File: sv/spat_if.sv
// Valid/ready channel interfaces of the translator: request, response, config.
// Depends on spat_pkg for the config field widths.
interface spat_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [31:0] logical_address;
  logic [15:0] selector;
  logic [9:0]  entry_index;
  logic [63:0] entry_value;

  modport source (output valid, opcode, logical_address, selector, entry_index,
                  entry_value, input ready);
  modport sink   (input valid, opcode, logical_address, selector, entry_index,
                  entry_value, output ready);
endinterface

interface spat_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] physical_address;
  logic [2:0]  status;

  modport source (output valid, physical_address, status, input ready);
  modport sink   (input valid, physical_address, status, output ready);
endinterface

interface spat_cfg_if import spat_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [COUNT_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: sv/spat_front.sv
// Front end: config registers, request accept and selector classification.
// Depends on spat_pkg and spat_if; feeds the command queue.
module spat_front import spat_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  spat_req_if.sink      req_i,
  spat_cfg_if.sink      cfg_i,
  output logic          push_valid_o,
  output cmd_t          push_cmd_o,
  input  logic          push_ready_i,
  output page_counts_t  page_counts_o
);

  logic [COUNT_W-1:0] global_count_q, local_count_q, dir_count_q, page_count_q;
  logic               use_local;
  logic [SEL_IDX_W-1:0] sel_idx;
  logic [SEL_IDX_W-1:0] wr_idx;
  logic [COUNT_W-1:0] sel_count;
  logic               sel_bad;
  logic               wr_ok;

  // Config registers, always ready
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      global_count_q <= '0;
      local_count_q  <= '0;
      dir_count_q    <= '0;
      page_count_q   <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_GLOBAL_COUNT: global_count_q <= cfg_i.data;
        CFG_LOCAL_COUNT:  local_count_q  <= cfg_i.data;
        CFG_DIR_COUNT:    dir_count_q    <= cfg_i.data;
        CFG_PAGE_COUNT:   page_count_q   <= cfg_i.data;
      endcase
    end
  end

  assign page_counts_o = '{dir_count: dir_count_q, page_count: page_count_q};

  // Selector check: null global index, index past count or depth
  assign use_local = req_i.selector[2];
  assign sel_idx   = req_i.selector[15:3];
  assign sel_count = use_local ? local_count_q : global_count_q;
  assign sel_bad   = (!use_local && (sel_idx == '0)) || !in_table(sel_idx, sel_count);

  assign wr_idx = SEL_IDX_W'(req_i.entry_index);
  assign wr_ok  = in_depth(wr_idx);

  // Classify the request into a queue command
  always_comb begin
    push_cmd_o.use_local = use_local;
    push_cmd_o.offset    = req_i.logical_address;
    push_cmd_o.data      = req_i.entry_value;
    push_cmd_o.addr      = tbl_addr(wr_idx);
    push_cmd_o.kind      = K_NOP;
    unique case (req_i.opcode)
      OP_TRANSLATE: begin
        push_cmd_o.kind = sel_bad ? K_BAD_SEL : K_TRANSLATE;
        push_cmd_o.addr = tbl_addr(sel_idx);
      end
      OP_WR_GLOBAL: push_cmd_o.kind = wr_ok ? K_WR_GLOBAL : K_NOP;
      OP_WR_LOCAL:  push_cmd_o.kind = wr_ok ? K_WR_LOCAL  : K_NOP;
      OP_WR_DIR:    push_cmd_o.kind = wr_ok ? K_WR_DIR    : K_NOP;
      OP_WR_PAGE:   push_cmd_o.kind = wr_ok ? K_WR_PAGE   : K_NOP;
      default:      push_cmd_o.kind = K_NOP;
    endcase
  end

  assign push_valid_o = req_i.valid;
  assign req_i.ready  = push_ready_i;

endmodule

// File: sv/spat_queue.sv
// Short command FIFO that decouples the front end from the back end.
// Depends on spat_pkg (cmd_t, QUEUE_DEPTH).
module spat_queue import spat_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  input  cmd_t push_cmd_i,
  output logic push_ready_o,
  output logic pop_valid_o,
  output cmd_t pop_cmd_o,
  input  logic pop_ready_i
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  cmd_t             entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [PTR_W:0]   fill_q;
  logic             push, pop;

  assign push_ready_o = (fill_q != (PTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid_o  = (fill_q != '0);
  assign pop_cmd_o    = entry_q[rd_ptr_q];

  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push && !pop)      fill_q <= fill_q + 1'b1;
      else if (pop && !push) fill_q <= fill_q - 1'b1;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push) entry_q[wr_ptr_q] <= push_cmd_i;
  end

endmodule

// File: sv/spat_back.sv
// Back end: descriptor and page tables, translation sequencer, response register.
// Depends on spat_pkg and spat_if; drains the command queue.
module spat_back import spat_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          pop_valid_i,
  input  cmd_t          pop_cmd_i,
  output logic          pop_ready_o,
  input  page_counts_t  page_counts_i,
  spat_rsp_if.source    rsp_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEG,
    S_PAGE,
    S_DONE
  } state_e;

  state_e      state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_phys_q, out_phys_d;
  status_e     out_status_q, out_status_d;

  logic        use_local_q;
  logic [31:0] offset_q;
  logic [31:0] linear_q, linear_d;

  logic [63:0] gdt_mem [TABLE_DEPTH];
  logic [63:0] ldt_mem [TABLE_DEPTH];
  logic [31:0] dir_mem [TABLE_DEPTH];
  logic [31:0] pg_mem  [TABLE_DEPTH];
  logic [63:0] gdt_rd_q, ldt_rd_q;
  logic [31:0] dir_rd_q, pg_rd_q;

  logic        pop;
  logic        start_xlate;
  logic [63:0] desc;
  logic [19:0] limit_raw;
  logic [31:0] limit;
  logic [31:0] base;
  logic [9:0]  dir_idx, pt_idx;
  logic        page_range_ok;
  logic [IDX_W-1:0] dir_addr, pt_addr;

  assign pop_ready_o = (state_q == S_IDLE) && (!out_valid_q || rsp_o.ready);
  assign pop         = pop_valid_i && pop_ready_o;
  assign start_xlate = pop && (pop_cmd_i.kind == K_TRANSLATE);

  // Descriptor fields
  assign desc      = use_local_q ? ldt_rd_q : gdt_rd_q;
  assign limit_raw = {desc[51:48], desc[15:0]};
  assign limit     = desc[55] ? {limit_raw, 12'hFFF} : {12'h000, limit_raw};
  assign base      = {desc[63:56], desc[39:32], desc[31:16]};

  // Page walk indices from the linear address
  assign dir_idx       = linear_q[31:22];
  assign pt_idx        = linear_q[21:12];
  assign page_range_ok = in_table(SEL_IDX_W'(dir_idx), page_counts_i.dir_count)
                      && in_table(SEL_IDX_W'(pt_idx), page_counts_i.page_count);
  assign dir_addr      = tbl_addr(SEL_IDX_W'(dir_idx));
  assign pt_addr       = tbl_addr(SEL_IDX_W'(pt_idx));

  // Sequencer next state and response
  always_comb begin
    state_d      = state_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_phys_d   = out_phys_q;
    out_status_d = out_status_q;
    linear_d     = linear_q;
    unique case (state_q)
      S_IDLE: begin
        if (pop) begin
          unique case (pop_cmd_i.kind)
            K_TRANSLATE: state_d = S_SEG;
            K_BAD_SEL: begin
              out_valid_d  = 1'b1;
              out_phys_d   = '0;
              out_status_d = ST_BAD_SELECTOR;
            end
            default: begin
              out_valid_d  = 1'b1;
              out_phys_d   = '0;
              out_status_d = ST_WRITTEN;
            end
          endcase
        end
      end
      S_SEG: begin
        if (!desc[47]) begin
          out_valid_d  = 1'b1;
          out_phys_d   = '0;
          out_status_d = ST_ABSENT;
          state_d      = S_IDLE;
        end else if (offset_q > limit) begin
          out_valid_d  = 1'b1;
          out_phys_d   = '0;
          out_status_d = ST_LIMIT;
          state_d      = S_IDLE;
        end else begin
          linear_d = base + offset_q;
          state_d  = S_PAGE;
        end
      end
      S_PAGE: begin
        if (!page_range_ok) begin
          out_valid_d  = 1'b1;
          out_phys_d   = '0;
          out_status_d = ST_PAGE_RANGE;
          state_d      = S_IDLE;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        out_valid_d = 1'b1;
        state_d     = S_IDLE;
        if (!dir_rd_q[0] || !pg_rd_q[0]) begin
          out_phys_d   = '0;
          out_status_d = ST_PAGE_ABSENT;
        end else begin
          out_phys_d   = {pg_rd_q[31:12], linear_q[11:0]};
          out_status_d = ST_OK;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State and response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_q  <= 1'b0;
      out_phys_q   <= '0;
      out_status_q <= ST_OK;
    end else begin
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
      out_phys_q   <= out_phys_d;
      out_status_q <= out_status_d;
    end
  end

  // Per-translation working registers
  always_ff @(posedge clk_i) begin
    if (start_xlate) begin
      use_local_q <= pop_cmd_i.use_local;
      offset_q    <= pop_cmd_i.offset;
    end
    linear_q <= linear_d;
  end

  // Descriptor tables: written by write commands, read when a translation starts
  always_ff @(posedge clk_i) begin
    if (pop && (pop_cmd_i.kind == K_WR_GLOBAL)) gdt_mem[pop_cmd_i.addr] <= pop_cmd_i.data;
    if (start_xlate) gdt_rd_q <= gdt_mem[pop_cmd_i.addr];
  end

  always_ff @(posedge clk_i) begin
    if (pop && (pop_cmd_i.kind == K_WR_LOCAL)) ldt_mem[pop_cmd_i.addr] <= pop_cmd_i.data;
    if (start_xlate) ldt_rd_q <= ldt_mem[pop_cmd_i.addr];
  end

  // Directory and page tables: read once the linear address is known
  always_ff @(posedge clk_i) begin
    if (pop && (pop_cmd_i.kind == K_WR_DIR)) dir_mem[pop_cmd_i.addr] <= pop_cmd_i.data[31:0];
    if (state_q == S_PAGE) dir_rd_q <= dir_mem[dir_addr];
  end

  always_ff @(posedge clk_i) begin
    if (pop && (pop_cmd_i.kind == K_WR_PAGE)) pg_mem[pop_cmd_i.addr] <= pop_cmd_i.data[31:0];
    if (state_q == S_PAGE) pg_rd_q <= pg_mem[pt_addr];
  end

  assign rsp_o.valid            = out_valid_q;
  assign rsp_o.physical_address = out_phys_q;
  assign rsp_o.status           = out_status_q;

endmodule

// File: sv/segment_page_address_translator_core.sv
// Top level of the segment/page address translator: front, queue and back.
// Depends on spat_pkg, spat_if, spat_front, spat_queue and spat_back.
//
// Each request gives exactly one response, in order. Table writes, unknown
// opcodes and requests whose selector is already rejected by the front end
// are answered without leaving the idle state. A translation that reaches the
// page tables passes descriptor read, limit check and base add, directory and
// page table read, and result; a fault ends the translation at the step that
// detects it. The back-end sequencer handles one command at a time against
// its synchronous table memories. A request first passes a 2-entry command
// queue, so the front keeps accepting while the back end works or while a
// response waits on rsp_o. The tables are not cleared by reset; an entry must
// be written before a translation reads it. Count registers must be written
// only while no request is outstanding; the block does not enforce it.
module segment_page_address_translator_core import spat_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  spat_req_if.sink    req_i,
  spat_rsp_if.source  rsp_o,
  spat_cfg_if.sink    cfg_i
);

  logic         push_valid, push_ready;
  cmd_t         push_cmd;
  logic         pop_valid, pop_ready;
  cmd_t         pop_cmd;
  page_counts_t page_counts;

  spat_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req_i),
    .cfg_i         (cfg_i),
    .push_valid_o  (push_valid),
    .push_cmd_o    (push_cmd),
    .push_ready_i  (push_ready),
    .page_counts_o (page_counts)
  );

  spat_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_cmd_i   (push_cmd),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_cmd_o    (pop_cmd),
    .pop_ready_i  (pop_ready)
  );

  spat_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pop_valid_i   (pop_valid),
    .pop_cmd_i     (pop_cmd),
    .pop_ready_o   (pop_ready),
    .page_counts_i (page_counts),
    .rsp_o         (rsp_o)
  );

endmodule

// File: sv/spat_checker.sv
// Port-level checks of the translator and the bind that attaches them.
// Depends on spat_pkg and segment_page_address_translator_core.
module spat_checker import spat_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid_i,
  input logic        req_ready_i,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [31:0] rsp_phys_i,
  input logic [2:0]  rsp_status_i,
  input logic        cfg_valid_i,
  input logic        cfg_ready_i
);

  logic [3:0] inflight_q;
  logic       req_xfer, rsp_xfer;

  assign req_xfer = req_valid_i && req_ready_i;
  assign rsp_xfer = rsp_valid_i && rsp_ready_i;

  // Requests accepted but not yet answered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else if (req_xfer && !rsp_xfer) begin
      inflight_q <= inflight_q + 1'b1;
    end else if (rsp_xfer && !req_xfer) begin
      inflight_q <= inflight_q - 1'b1;
    end
  end

  a_fault_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i != ST_OK) |-> (rsp_phys_i == '0))
    else $error("fault response with nonzero address");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_status_i)
                                    && $stable(rsp_phys_i))
    else $error("stalled response changed");

  a_no_spurious_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (inflight_q != '0))
    else $error("response without an outstanding request");

  a_inflight_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= 4'(QUEUE_DEPTH + 1))
    else $error("more requests in flight than the queue and back end hold");

  // Config port never stalls
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_i)
    else $error("config write stalled");

endmodule

bind segment_page_address_translator_core spat_checker u_spat_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_phys_i   (rsp_o.physical_address),
  .rsp_status_i (rsp_o.status),
  .cfg_valid_i  (cfg_i.valid),
  .cfg_ready_i  (cfg_i.ready)
);

// File: tb/segment_page_address_translator_core_test.sv
// Testbench for segment_page_address_translator_core: directed and random requests,
// table counts set between phases, each response predicted and checked in order.
// Depends on spat_pkg and the channel interfaces spat_req_if, spat_rsp_if, spat_cfg_if.
module segment_page_address_translator_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import spat_pkg::*;

  // Slowest run: ~1100 requests, each with the longest send gap, response stall
  // and back-end pass, plus one long receiver hold-off.
  localparam int CYCLE_LIMIT   = 400_000;
  localparam int MAX_REPORTS   = 10;
  // Back end plus command queue, so the block is idle before a count write
  localparam int SETTLE_CYCLES = 12;
  localparam logic [2:0] OP_FIRST_UNUSED = OP_WR_PAGE + 3'd1;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] logical_address;
    logic [15:0] selector;
    logic [9:0]  entry_index;
    logic [63:0] entry_value;
  } xlat_req_t;

  typedef struct packed {
    logic [31:0] physical_address;
    status_e     status;
  } xlat_rsp_t;

  logic clk_i;
  logic rst_ni;

  spat_req_if req ();
  spat_rsp_if rsp ();
  spat_cfg_if cfg ();

  segment_page_address_translator_core dut (
    .clk_i,
    .rst_ni,
    .req_i (req),
    .rsp_o (rsp),
    .cfg_i (cfg)
  );

  // Shadow tables, which entries hold data, and the programmed counts
  logic [63:0] gdt_mem  [TABLE_DEPTH];
  logic [63:0] ldt_mem  [TABLE_DEPTH];
  logic [31:0] pdir_mem [TABLE_DEPTH];
  logic [31:0] ptab_mem [TABLE_DEPTH];
  bit          gdt_set  [TABLE_DEPTH];
  bit          ldt_set  [TABLE_DEPTH];
  bit          pdir_set [TABLE_DEPTH];
  bit          ptab_set [TABLE_DEPTH];
  int unsigned gdt_used[$], ldt_used[$], pdir_used[$], ptab_used[$];
  int unsigned gdt_count, ldt_count, pdir_count, ptab_count;

  xlat_rsp_t   awaited_responses[$];

  int unsigned cycle_count;
  int unsigned error_count;
  int unsigned requests_sent;
  int unsigned responses_checked;
  int unsigned count_writes;
  int unsigned status_seen [8];

  bit          sender_quiet;
  bit          receiver_quiet;
  int unsigned hold_len;
  int unsigned hold_serial;
  int unsigned hold_seen;
  int unsigned stall_left;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Cycle limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d responses still awaited",
               cycle_count, awaited_responses.size());
      $display("Verification failed");
      $finish;
    end
  end

  function automatic int unsigned pct();
    return $urandom_range(0, 99);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Idle cycles between requests: mostly none, some short, a few long
  function automatic int unsigned sender_gap();
    int unsigned p;
    p = pct();
    if (sender_quiet || p < 70) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int unsigned stall_len();
    if (pct() < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Response ready, with random stalls and requested hold-offs
  always @(posedge clk_i) begin
    if (hold_serial != hold_seen) begin
      hold_seen  = hold_serial;
      stall_left = hold_len;
    end
    if (!rst_ni) begin
      rsp.ready <= 1'b0;
    end else if (stall_left != 0) begin
      rsp.ready <= 1'b0;
      stall_left--;
    end else if (receiver_quiet || pct() < 75) begin
      rsp.ready <= 1'b1;
    end else begin
      rsp.ready  <= 1'b0;
      stall_left = stall_len() - 1;
    end
  end

  // Descriptor fields
  function automatic logic [31:0] desc_base(logic [63:0] d);
    return {d[63:56], d[39:32], d[31:16]};
  endfunction

  function automatic logic [31:0] desc_limit(logic [63:0] d);
    logic [31:0] lim;
    lim = {12'd0, d[51:48], d[15:0]};
    // Page granularity: limit counts 4 KiB units, low 12 bits all ones
    if (d[55]) lim = {lim[19:0], 12'hFFF};
    return lim;
  endfunction

  function automatic logic [63:0] make_desc(logic [31:0] base, logic [19:0] lim, bit present,
                                            bit gran);
    logic [63:0] d;
    d        = rand64();
    d[15:0]  = lim[15:0];
    d[51:48] = lim[19:16];
    d[31:16] = base[15:0];
    d[39:32] = base[23:16];
    d[63:56] = base[31:24];
    d[47]    = present;
    d[55]    = gran;
    return d;
  endfunction

  function automatic logic [63:0] page_word(bit present);
    logic [63:0] w;
    w    = rand64();
    w[0] = present;
    return w;
  endfunction

  // Expected translation; unsafe flags a read of a table entry never written
  function automatic void translate_address(input logic [31:0] offset, input logic [15:0] sel,
                                            output logic [31:0] phys, output status_e st,
                                            output bit unsafe);
    bit          use_ldt;
    int unsigned idx, count, dir_i, pt_i;
    logic [63:0] desc;
    logic [31:0] linear;
    use_ldt = sel[2];
    idx     = sel[15:3];
    count   = use_ldt ? ldt_count : gdt_count;
    phys    = '0;
    unsafe  = 1'b0;
    // Null global selector, or index past the count or the table
    if ((!use_ldt && idx == 0) || idx >= count || idx >= TABLE_DEPTH) begin
      st = ST_BAD_SELECTOR;
      return;
    end
    desc   = use_ldt ? ldt_mem[idx] : gdt_mem[idx];
    unsafe = use_ldt ? !ldt_set[idx] : !gdt_set[idx];
    if (!desc[47]) begin
      st = ST_ABSENT;
      return;
    end
    if (offset > desc_limit(desc)) begin
      st = ST_LIMIT;
      return;
    end
    linear = desc_base(desc) + offset;
    dir_i  = linear[31:22];
    pt_i   = linear[21:12];
    // Both page entries may be fetched once the segment checks pass
    unsafe = unsafe || !pdir_set[dir_i] || !ptab_set[pt_i];
    if (dir_i >= pdir_count || pt_i >= ptab_count || dir_i >= TABLE_DEPTH
        || pt_i >= TABLE_DEPTH) begin
      st = ST_PAGE_RANGE;
      return;
    end
    if (!pdir_mem[dir_i][0] || !ptab_mem[pt_i][0]) begin
      st = ST_PAGE_ABSENT;
      return;
    end
    phys = {ptab_mem[pt_i][31:12], linear[11:0]};
    st   = ST_OK;
  endfunction

  // Update the shadow state for one accepted request, return its response
  function automatic xlat_rsp_t apply_request(xlat_req_t r);
    xlat_rsp_t   res;
    logic [31:0] phys;
    status_e     st;
    bit          unsafe;
    int unsigned i;
    i     = r.entry_index;
    phys  = '0;
    st    = ST_WRITTEN;
    case (r.opcode)
      OP_TRANSLATE: translate_address(r.logical_address, r.selector, phys, st, unsafe);
      OP_WR_GLOBAL: if (i < TABLE_DEPTH) begin
        if (!gdt_set[i]) gdt_used.push_back(i);
        gdt_set[i] = 1'b1;
        gdt_mem[i] = r.entry_value;
      end
      OP_WR_LOCAL: if (i < TABLE_DEPTH) begin
        if (!ldt_set[i]) ldt_used.push_back(i);
        ldt_set[i] = 1'b1;
        ldt_mem[i] = r.entry_value;
      end
      OP_WR_DIR: if (i < TABLE_DEPTH) begin
        if (!pdir_set[i]) pdir_used.push_back(i);
        pdir_set[i] = 1'b1;
        pdir_mem[i] = r.entry_value[31:0];
      end
      OP_WR_PAGE: if (i < TABLE_DEPTH) begin
        if (!ptab_set[i]) ptab_used.push_back(i);
        ptab_set[i] = 1'b1;
        ptab_mem[i] = r.entry_value[31:0];
      end
      default: ;
    endcase
    res.physical_address = phys;
    res.status           = st;
    return res;
  endfunction

  function automatic xlat_req_t write_req(logic [2:0] op, int unsigned idx, logic [63:0] val);
    xlat_req_t r;
    r.opcode          = op;
    r.logical_address = $urandom();
    r.selector        = $urandom();
    r.entry_index     = idx;
    r.entry_value     = val;
    return r;
  endfunction

  function automatic xlat_req_t translate_req(logic [15:0] sel, logic [31:0] off);
    xlat_req_t r;
    r.opcode          = OP_TRANSLATE;
    r.logical_address = off;
    r.selector        = sel;
    r.entry_index     = $urandom();
    r.entry_value     = rand64();
    return r;
  endfunction

  function automatic logic [15:0] make_sel(int unsigned idx, bit use_ldt);
    return {idx[12:0], use_ldt, 2'($urandom())};
  endfunction

  // Table write, mostly inside the programmed count
  function automatic xlat_req_t random_write_req();
    int unsigned p, region, idx;
    logic [2:0]  op;
    logic [63:0] val;
    p = pct();
    if (p < 30) begin
      op     = OP_WR_GLOBAL;
      region = gdt_count;
    end else if (p < 50) begin
      op     = OP_WR_LOCAL;
      region = ldt_count;
    end else if (p < 75) begin
      op     = OP_WR_DIR;
      region = pdir_count;
    end else begin
      op     = OP_WR_PAGE;
      region = ptab_count;
    end
    if (region < 1) region = 1;
    if (region > TABLE_DEPTH) region = TABLE_DEPTH;
    idx = (pct() < 70) ? $urandom_range(0, region - 1) : $urandom_range(0, TABLE_DEPTH - 1);
    if (op == OP_WR_GLOBAL || op == OP_WR_LOCAL) begin
      val = make_desc((pct() < 30) ? $urandom_range(0, 32'h00FF_FFFF) : $urandom(),
                      $urandom(), pct() < 85, pct() < 60);
    end else begin
      val = page_word(pct() < 85);
    end
    return write_req(op, idx, val);
  endfunction

  // Translation that only touches written entries, mostly aimed at present pages
  function automatic void pick_translation(output xlat_req_t r, output bit found);
    int unsigned tries, idx, q, dir_pick, pt_pick;
    bit          use_ldt, unsafe;
    logic [63:0] d;
    logic [31:0] off, lim, linear, phys;
    logic [15:0] sel;
    status_e     st;
    found = 1'b0;
    for (tries = 0; tries < 40 && !found; tries++) begin
      use_ldt = ldt_used.size() != 0 && (gdt_used.size() == 0 || pct() < 40);
      if (pct() < 15 || (gdt_used.size() == 0 && ldt_used.size() == 0)) begin
        sel = $urandom();
        off = $urandom();
      end else begin
        idx = use_ldt ? ldt_used[$urandom_range(0, ldt_used.size() - 1)]
                      : gdt_used[$urandom_range(0, gdt_used.size() - 1)];
        d   = use_ldt ? ldt_mem[idx] : gdt_mem[idx];
        sel = make_sel(idx, use_ldt);
        lim = desc_limit(d);
        q   = pct();
        if (q < 65 && pdir_used.size() != 0 && ptab_used.size() != 0) begin
          dir_pick = pdir_used[$urandom_range(0, pdir_used.size() - 1)];
          pt_pick  = ptab_used[$urandom_range(0, ptab_used.size() - 1)];
          linear   = (dir_pick << 22) | (pt_pick << 12) | $urandom_range(0, 4095);
          off      = linear - desc_base(d);
        end else if (q < 85) begin
          off = $urandom_range(0, lim);
        end else if (q < 92) begin
          off = lim + $urandom_range(0, 1);
        end else begin
          off = $urandom();
        end
      end
      translate_address(off, sel, phys, st, unsafe);
      if (!unsafe) begin
        found = 1'b1;
        r     = translate_req(sel, off);
      end
    end
  endfunction

  function automatic xlat_req_t random_request();
    xlat_req_t   r;
    bit          found;
    int unsigned p;
    p = pct();
    if (p < 4) return write_req(OP_FIRST_UNUSED + 3'($urandom_range(0, 2)), $urandom(),
                                rand64());
    if (p < 28) return random_write_req();
    pick_translation(r, found);
    if (!found) r = random_write_req();
    return r;
  endfunction

  // One request transfer; prediction happens at acceptance
  task automatic send_request(input xlat_req_t r);
    int unsigned gap;
    req.valid           <= 1'b1;
    req.opcode          <= r.opcode;
    req.logical_address <= r.logical_address;
    req.selector        <= r.selector;
    req.entry_index     <= r.entry_index;
    req.entry_value     <= r.entry_value;
    do @(posedge clk_i); while (!req.ready);
    awaited_responses.push_back(apply_request(r));
    requests_sent++;
    gap = sender_gap();
    if (gap != 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Sender pauses until every response is back and the block has settled
  task automatic wait_idle();
    req.valid <= 1'b0;
    while (awaited_responses.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(input cfg_reg_e which, input int unsigned value);
    cfg.valid <= 1'b1;
    cfg.index <= which;
    cfg.data  <= COUNT_W'(value);
    do @(posedge clk_i); while (!cfg.ready);
    count_writes++;
    case (which)
      CFG_GLOBAL_COUNT: gdt_count  = value % (1 << COUNT_W);
      CFG_LOCAL_COUNT:  ldt_count  = value % (1 << COUNT_W);
      CFG_DIR_COUNT:    pdir_count = value % (1 << COUNT_W);
      CFG_PAGE_COUNT:   ptab_count = value % (1 << COUNT_W);
      default: ;
    endcase
  endtask

  task automatic program_counts(input int unsigned g, input int unsigned l,
                                input int unsigned d, input int unsigned p);
    wait_idle();
    write_register(CFG_GLOBAL_COUNT, g);
    write_register(CFG_LOCAL_COUNT, l);
    write_register(CFG_DIR_COUNT, d);
    write_register(CFG_PAGE_COUNT, p);
    cfg.valid <= 1'b0;
  endtask

  // Every status, both tables, limit and granularity edges, extreme addresses
  task automatic test_directed_cases();
    program_counts(4, 2, 4, 8);
    send_request(write_req(OP_WR_GLOBAL, 1, make_desc(32'h0, 20'hFFFFF, 1'b1, 1'b1)));
    send_request(write_req(OP_WR_GLOBAL, 2, make_desc($urandom(), $urandom(), 1'b0,
                                                      pct() < 50)));
    send_request(write_req(OP_WR_GLOBAL, 3, make_desc(32'hFFFF_F000, 20'h00FFF, 1'b1, 1'b0)));
    send_request(write_req(OP_WR_LOCAL, 1, make_desc(32'h0040_0000, 20'h00001, 1'b1, 1'b1)));
    send_request(write_req(OP_WR_DIR, 0, page_word(1'b1)));
    send_request(write_req(OP_WR_DIR, 1, page_word(1'b1)));
    send_request(write_req(OP_WR_DIR, 3, page_word(1'b0)));
    send_request(write_req(OP_WR_DIR, TABLE_DEPTH - 1, page_word(1'b1)));
    send_request(write_req(OP_WR_PAGE, 0, {$urandom(), 32'hABCD_E001}));
    send_request(write_req(OP_WR_PAGE, 1, {$urandom(), 32'hFFFF_F001}));
    send_request(write_req(OP_WR_PAGE, 2, page_word(1'b0)));
    send_request(write_req(OP_WR_PAGE, TABLE_DEPTH - 1, page_word(1'b1)));
    // Null global, local past its count
    send_request(translate_req(make_sel(0, 1'b0), $urandom()));
    send_request(translate_req(make_sel(8191, 1'b1), $urandom()));
    // Flat segment: lowest address, all-ones frame, absent page, absent directory
    send_request(translate_req(make_sel(1, 1'b0), 32'h0));
    send_request(translate_req(make_sel(1, 1'b0), 32'h0000_1FFF));
    send_request(translate_req(make_sel(1, 1'b0), 32'h0000_2000));
    send_request(translate_req(make_sel(1, 1'b0), 32'h00C0_0000));
    // Absent segment; byte-granular limit edge, whose last byte lies in the top page
    send_request(translate_req(make_sel(2, 1'b0), $urandom()));
    send_request(translate_req(make_sel(3, 1'b0), 32'h0000_1000));
    send_request(translate_req(make_sel(3, 1'b0), 32'h0000_0FFF));
    // Page-granular local segment: last byte inside, first byte outside
    send_request(translate_req(make_sel(1, 1'b1), 32'h0000_1FFF));
    send_request(translate_req(make_sel(1, 1'b1), 32'h0000_2000));
    send_request(write_req(OP_FIRST_UNUSED + 3'($urandom_range(0, 2)), $urandom(), rand64()));
    // Full counts: index past the table, top offset now reaches the last page
    program_counts(TABLE_DEPTH, TABLE_DEPTH, TABLE_DEPTH, TABLE_DEPTH);
    send_request(translate_req(make_sel(TABLE_DEPTH, 1'b0), $urandom()));
    send_request(translate_req(make_sel(1, 1'b0), 32'hFFFF_FFFF));
  endtask

  task automatic test_random_traffic(input int unsigned g, input int unsigned l,
                                     input int unsigned d, input int unsigned p,
                                     input int unsigned n);
    program_counts(g, l, d, p);
    repeat (n) send_request(random_request());
  endtask

  // Receiver holds off while requests keep coming, so the input stalls
  task automatic test_backpressure();
    hold_len     = 200;
    hold_serial++;
    sender_quiet = 1'b1;
    repeat (24) send_request(random_request());
    sender_quiet = 1'b0;
  endtask

  task automatic test_drain_and_resume();
    repeat (30) send_request(random_request());
    wait_idle();
    repeat (30) send_request(random_request());
  endtask

  task automatic test_steady_stream();
    sender_quiet   = 1'b1;
    receiver_quiet = 1'b1;
    repeat (60) send_request(random_request());
    sender_quiet   = 1'b0;
    receiver_quiet = 1'b0;
  endtask

  // Response check against the oldest awaited response
  always @(posedge clk_i) begin : check_responses
    xlat_rsp_t want;
    if (rst_ni && rsp.valid && rsp.ready) begin
      responses_checked++;
      status_seen[rsp.status]++;
      if (awaited_responses.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS) begin
          $display("Cycle %0d: response with nothing awaited: phys %h status %0d",
                   cycle_count, rsp.physical_address, rsp.status);
        end
      end else begin
        want = awaited_responses.pop_front();
        if (rsp.physical_address !== want.physical_address || rsp.status !== want.status) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("Cycle %0d: expected phys %h status %0d, got phys %h status %0d",
                     cycle_count, want.physical_address, want.status,
                     rsp.physical_address, rsp.status);
          end
        end
      end
    end
  end

  task automatic finish_run();
    wait_idle();
    error_count += awaited_responses.size();
    $display("Run covered %0d requests, %0d responses, %0d count writes, %0d mismatches",
             requests_sent, responses_checked, count_writes, error_count);
    $display("Status mix: ok %0d, selector %0d, absent %0d, limit %0d, range %0d, page %0d, write %0d",
             status_seen[ST_OK], status_seen[ST_BAD_SELECTOR], status_seen[ST_ABSENT],
             status_seen[ST_LIMIT], status_seen[ST_PAGE_RANGE], status_seen[ST_PAGE_ABSENT],
             status_seen[ST_WRITTEN]);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  endtask

  // Test sequence
  initial begin
    rst_ni              = 1'b0;
    req.valid           = 1'b0;
    req.opcode          = OP_TRANSLATE;
    req.logical_address = '0;
    req.selector        = '0;
    req.entry_index     = '0;
    req.entry_value     = '0;
    rsp.ready           = 1'b0;
    cfg.valid           = 1'b0;
    cfg.index           = CFG_GLOBAL_COUNT;
    cfg.data            = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_random_traffic(TABLE_DEPTH, TABLE_DEPTH, TABLE_DEPTH, TABLE_DEPTH, 280);
    test_backpressure();
    test_random_traffic($urandom_range(1, TABLE_DEPTH), $urandom_range(1, TABLE_DEPTH),
                        $urandom_range(1, TABLE_DEPTH), $urandom_range(1, TABLE_DEPTH), 220);
    test_drain_and_resume();
    test_random_traffic($urandom_range(2, 16), $urandom_range(1, 16),
                        $urandom_range(1, 16), $urandom_range(1, 16), 200);
    test_random_traffic(0, 0, 0, 0, 40);
    test_steady_stream();
    test_random_traffic(TABLE_DEPTH, 0, $urandom_range(1, TABLE_DEPTH), TABLE_DEPTH, 160);
    finish_run();
  end

endmodule
